>>> sv/lru_page_replacement_top_defines.svh
// Assertion helpers shared by the replacement table logic.
// Both sample on clk and are switched off while rst_n is low.
`ifndef LRU_PAGE_REPLACEMENT_TOP_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_TOP_DEFINES_SVH

// Same-cycle implication
`define LRU_PR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lru_page_replacement: same-cycle check failed");

// Next-cycle implication
`define LRU_PR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lru_page_replacement: next-cycle check failed");

`endif

>>> sv/lru_pr_pkg.sv
package lru_pr_pkg;

  // Table geometry
  localparam int FRAMES    = 8;
  localparam int PAGE_BITS = 16;
  localparam int SLOT_W    = $clog2(FRAMES);
  localparam int RANK_W    = $clog2(FRAMES);
  localparam int CNT_W     = $clog2(FRAMES + 1);
  localparam int CFG_W     = 4;
  localparam int FAULT_W   = 32;

  localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(8);
  localparam logic [RANK_W-1:0] RANK_MAX  = RANK_W'(FRAMES - 1);

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [RANK_W-1:0]    rank_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // Input beat
  typedef struct packed {
    page_t page_number;
    logic  last_reference;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic               hit;
    slot_t              frame_slot;
    logic               evicted_valid;
    page_t              evicted_page;
    logic [FAULT_W-1:0] fault_count;
  } out_beat_t;

  // Lookup decision handed to the table update
  typedef struct packed {
    logic  hit;
    slot_t slot;
    logic  fill_used;
    logic  was_valid;
    logic  ev_valid;
    page_t ev_page;
  } lookup_t;

endpackage

>>> sv/lru_pr_lookup.sv
module lru_pr_lookup (
  input  lru_pr_pkg::page_t           pages [lru_pr_pkg::FRAMES],
  input  logic [lru_pr_pkg::FRAMES-1:0] valid,
  input  lru_pr_pkg::rank_t           ranks [lru_pr_pkg::FRAMES],
  input  lru_pr_pkg::slot_t           fill_ptr,
  input  lru_pr_pkg::cnt_t            n_frames,
  input  lru_pr_pkg::page_t           page,
  output lru_pr_pkg::lookup_t         res
);

  logic [lru_pr_pkg::FRAMES-1:0] managed;
  logic [lru_pr_pkg::FRAMES-1:0] match;
  logic [lru_pr_pkg::FRAMES-1:0] empty;
  lru_pr_pkg::slot_t             hit_idx;
  lru_pr_pkg::slot_t             empty_idx;
  lru_pr_pkg::slot_t             lru_idx;
  lru_pr_pkg::rank_t             best;
  logic                          fill_ok;

  // Parallel tag compare and empty detect over the managed frames
  always_comb begin
    for (int g = 0; g < lru_pr_pkg::FRAMES; g++) begin
      managed[g] = (g < int'(n_frames));
      match[g]   = valid[g] && managed[g] && (pages[g] == page);
      empty[g]   = !valid[g] && managed[g];
    end
  end

  // Lowest-index priority encoders
  always_comb begin
    hit_idx   = '0;
    empty_idx = '0;
    for (int g = lru_pr_pkg::FRAMES - 1; g >= 0; g--) begin
      if (match[g]) begin
        hit_idx = lru_pr_pkg::SLOT_W'(g);
      end
      if (empty[g]) begin
        empty_idx = lru_pr_pkg::SLOT_W'(g);
      end
    end
  end

  // Oldest managed frame, ties to the lowest index (frame 0 is always managed)
  always_comb begin
    lru_idx = '0;
    best    = ranks[0];
    for (int g = 1; g < lru_pr_pkg::FRAMES; g++) begin
      if (managed[g] && (ranks[g] > best)) begin
        best    = ranks[g];
        lru_idx = lru_pr_pkg::SLOT_W'(g);
      end
    end
  end

  // Fill slot is only used when it lies in range and is empty
  assign fill_ok = (lru_pr_pkg::CNT_W'(fill_ptr) < n_frames) && !valid[fill_ptr];

  // Victim selection
  always_comb begin
    res           = '0;
    res.hit       = |match;
    if (|match) begin
      res.slot      = hit_idx;
      res.was_valid = 1'b1;
    end else if (fill_ok) begin
      res.slot      = fill_ptr;
      res.fill_used = 1'b1;
    end else if (|empty) begin
      res.slot      = empty_idx;
    end else begin
      res.slot      = lru_idx;
      res.was_valid = 1'b1;
      res.ev_valid  = 1'b1;
      res.ev_page   = pages[lru_idx];
    end
  end

endmodule

>>> sv/lru_pr_table.sv
`include "lru_page_replacement_top_defines.svh"

module lru_pr_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  lru_pr_pkg::in_beat_t          beat,
  input  logic [lru_pr_pkg::CFG_W-1:0]  frames_cfg,
  output lru_pr_pkg::out_beat_t         res
);

  // Table state; page contents carry no reset
  lru_pr_pkg::page_t             pages_r [lru_pr_pkg::FRAMES];
  logic [lru_pr_pkg::FRAMES-1:0] valid_r;
  logic [lru_pr_pkg::FRAMES-1:0] valid_nxt;
  lru_pr_pkg::rank_t             rank_r [lru_pr_pkg::FRAMES];
  lru_pr_pkg::rank_t             rank_nxt [lru_pr_pkg::FRAMES];
  lru_pr_pkg::slot_t             fptr_r;
  lru_pr_pkg::slot_t             fptr_nxt;
  logic [lru_pr_pkg::FAULT_W-1:0] faults_r;
  logic [lru_pr_pkg::FAULT_W-1:0] faults_nxt;
  logic [lru_pr_pkg::FAULT_W-1:0] fault_upd;
  lru_pr_pkg::cnt_t              n_frames;
  lru_pr_pkg::lookup_t           lk;

  // Managed frame count: zero acts as one, large values clamp to the table size
  always_comb begin
    if (frames_cfg == '0) begin
      n_frames = lru_pr_pkg::CNT_W'(1);
    end else if (int'(frames_cfg) > lru_pr_pkg::FRAMES) begin
      n_frames = lru_pr_pkg::CNT_W'(lru_pr_pkg::FRAMES);
    end else begin
      n_frames = lru_pr_pkg::CNT_W'(frames_cfg);
    end
  end

  lru_pr_lookup u_lookup (
    .pages    (pages_r),
    .valid    (valid_r),
    .ranks    (rank_r),
    .fill_ptr (fptr_r),
    .n_frames (n_frames),
    .page     (beat.page_number),
    .res      (lk)
  );

  // Saturating fault counter, value shown with this beat
  always_comb begin
    fault_upd = faults_r;
    if (!lk.hit && (faults_r != '1)) begin
      fault_upd = faults_r + 1'b1;
    end
  end

  // Recency, valid and fill pointer update
  always_comb begin
    lru_pr_pkg::rank_t old_rank;
    old_rank   = rank_r[lk.slot];
    valid_nxt  = valid_r;
    rank_nxt   = rank_r;
    fptr_nxt   = fptr_r;
    faults_nxt = fault_upd;
    for (int g = 0; g < lru_pr_pkg::FRAMES; g++) begin
      if ((g < int'(n_frames)) && (lru_pr_pkg::SLOT_W'(g) != lk.slot) && valid_r[g] &&
          (!lk.was_valid || (rank_r[g] < old_rank)) && (rank_r[g] < lru_pr_pkg::RANK_MAX)) begin
        rank_nxt[g] = rank_r[g] + 1'b1;
      end
    end
    rank_nxt[lk.slot]  = '0;
    valid_nxt[lk.slot] = 1'b1;
    if (lk.fill_used) begin
      if ((lru_pr_pkg::CNT_W'(fptr_r) + lru_pr_pkg::CNT_W'(1)) >= n_frames) begin
        fptr_nxt = '0;
      end else begin
        fptr_nxt = fptr_r + 1'b1;
      end
    end
    // end of reference string: back to the reset picture
    if (beat.last_reference) begin
      valid_nxt  = '0;
      fptr_nxt   = '0;
      faults_nxt = '0;
      for (int g = 0; g < lru_pr_pkg::FRAMES; g++) begin
        rank_nxt[g] = '0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      fptr_r   <= '0;
      faults_r <= '0;
      for (int g = 0; g < lru_pr_pkg::FRAMES; g++) begin
        rank_r[g] <= '0;
      end
    end else if (step) begin
      valid_r  <= valid_nxt;
      fptr_r   <= fptr_nxt;
      faults_r <= faults_nxt;
      rank_r   <= rank_nxt;
    end
  end

  // Page store write on a fault
  always_ff @(posedge clk) begin
    if (step && !lk.hit) begin
      pages_r[lk.slot] <= beat.page_number;
    end
  end

  // Result for this beat
  always_comb begin
    res.hit           = lk.hit;
    res.frame_slot    = lk.slot;
    res.evicted_valid = lk.ev_valid;
    res.evicted_page  = lk.ev_page;
    res.fault_count   = fault_upd;
  end

  // Checks
  `LRU_PR_ASSERT_NXT(a_last_clears, step && beat.last_reference, valid_r == '0 && faults_r == '0)
  `LRU_PR_ASSERT_NXT(a_faults_mono, step && !beat.last_reference, faults_r >= $past(faults_r))
  `LRU_PR_ASSERT_IMP(a_evict_resident, step && lk.ev_valid, valid_r[lk.slot] && !lk.hit)
  `LRU_PR_ASSERT_NXT(a_touch_mru, step && !beat.last_reference, valid_r[$past(lk.slot)] && rank_r[$past(lk.slot)] == '0)

endmodule

>>> sv/lru_page_replacement_top.sv
// A result beat is loaded into the result register when its input beat leaves the input register.
// Throughput: one reference per cycle sustained while out_stall is low; lookup, victim choice and
// recency update share a single pass between the input and result registers.
// Reset (rst_n low, synchronous): both channel registers empty, valid bits,
// ranks, fill pointer and fault count cleared, frame count set to 8.
// Page contents are not cleared; they are read only behind a valid bit.
module lru_page_replacement_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lru_pr_pkg::in_beat_t          in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lru_pr_pkg::out_beat_t         out_data,
  input  logic                          cfg_we,
  input  logic [lru_pr_pkg::CFG_W-1:0]  cfg_data
);

  logic [lru_pr_pkg::CFG_W-1:0]   frames_cfg_r;
  logic                           in_vld_r;
  lru_pr_pkg::in_beat_t           in_beat_r;
  logic                           out_vld_r;
  lru_pr_pkg::out_beat_t          out_beat_r;
  lru_pr_pkg::out_beat_t          res;
  logic                           adv;
  logic                           step;

  // Frame count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_cfg_r <= lru_pr_pkg::CFG_RESET;
    end else if (cfg_we) begin
      frames_cfg_r <= cfg_data;
    end
  end

  // Result register drains or is empty: the held beat can move on
  assign adv      = !out_vld_r || !out_stall;
  assign step     = in_vld_r && adv;
  assign in_stall = in_vld_r && !adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_beat_r <= in_data;
    end
  end

  lru_pr_table u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .beat       (in_beat_r),
    .frames_cfg (frames_cfg_r),
    .res        (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_beat_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_beat_r;

endmodule

>>> tb/tb_lru_page_replacement_top.sv
`timescale 1ns / 1ps

module tb_lru_page_replacement_top;

  localparam int RANDOM_ITEMS = 400;
  localparam int QUIET_ITEMS  = 60;
  localparam int LIMIT_CYCLES = 200000;
  localparam int REF_ROWS     = 24;

  typedef enum logic {ROW_REF, ROW_CFG} row_kind_t;

  // One row of the directed sequence; typed rows carry their own result
  typedef struct {
    row_kind_t                      kind;
    logic [lru_pr_pkg::CFG_W-1:0]   frames;
    lru_pr_pkg::page_t              page;
    logic                           last;
    bit                             typed;
    logic                           hit;
    lru_pr_pkg::slot_t              slot;
    logic                           ev_valid;
    lru_pr_pkg::page_t              ev_page;
    logic [lru_pr_pkg::FAULT_W-1:0] faults;
  } ref_row_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  lru_pr_pkg::in_beat_t         in_data = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  lru_pr_pkg::out_beat_t        out_data;
  logic                         cfg_we = 1'b0;
  logic [lru_pr_pkg::CFG_W-1:0] cfg_data = '0;

  // Directed sequence: fill, LRU eviction, end of string, frame count edges
  ref_row_t ref_rows [REF_ROWS] = '{
    '{ROW_REF, 4'd0,  16'h0000, 1'b0, 1'b1, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd1},
    '{ROW_REF, 4'd0,  16'hFFFF, 1'b0, 1'b1, 1'b0, 3'd1, 1'b0, 16'h0000, 32'd2},
    '{ROW_REF, 4'd0,  16'h0000, 1'b0, 1'b1, 1'b1, 3'd0, 1'b0, 16'h0000, 32'd2},
    '{ROW_REF, 4'd0,  16'hAAAA, 1'b0, 1'b1, 1'b0, 3'd2, 1'b0, 16'h0000, 32'd3},
    '{ROW_REF, 4'd0,  16'h5555, 1'b0, 1'b1, 1'b0, 3'd3, 1'b0, 16'h0000, 32'd4},
    '{ROW_REF, 4'd0,  16'h0001, 1'b0, 1'b1, 1'b0, 3'd4, 1'b0, 16'h0000, 32'd5},
    '{ROW_REF, 4'd0,  16'h8000, 1'b0, 1'b1, 1'b0, 3'd5, 1'b0, 16'h0000, 32'd6},
    '{ROW_REF, 4'd0,  16'h1234, 1'b0, 1'b1, 1'b0, 3'd6, 1'b0, 16'h0000, 32'd7},
    '{ROW_REF, 4'd0,  16'h7FFF, 1'b0, 1'b1, 1'b0, 3'd7, 1'b0, 16'h0000, 32'd8},
    // table full: oldest page goes
    '{ROW_REF, 4'd0,  16'h4321, 1'b0, 1'b1, 1'b0, 3'd1, 1'b1, 16'hFFFF, 32'd9},
    '{ROW_REF, 4'd0,  16'h4321, 1'b1, 1'b1, 1'b1, 3'd1, 1'b0, 16'h0000, 32'd9},
    // stale page after clear must not hit
    '{ROW_REF, 4'd0,  16'hFFFF, 1'b0, 1'b1, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd1},
    // count of zero manages one frame; fill pointer out of range
    '{ROW_CFG, 4'd0,  16'h0000, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd0},
    '{ROW_REF, 4'd0,  16'h0042, 1'b0, 1'b1, 1'b0, 3'd0, 1'b1, 16'hFFFF, 32'd2},
    '{ROW_REF, 4'd0,  16'h0042, 1'b0, 1'b1, 1'b1, 3'd0, 1'b0, 16'h0000, 32'd2},
    '{ROW_CFG, 4'd15, 16'h0000, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd0},
    '{ROW_REF, 4'd0,  16'h0100, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd0},
    '{ROW_REF, 4'd0,  16'h0042, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd0},
    '{ROW_CFG, 4'd3,  16'h0000, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd0},
    '{ROW_REF, 4'd0,  16'h0200, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd0},
    '{ROW_REF, 4'd0,  16'h0300, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd0},
    '{ROW_REF, 4'd0,  16'h0100, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd0},
    '{ROW_REF, 4'd0,  16'h0400, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd0},
    '{ROW_REF, 4'd0,  16'hFFFF, 1'b1, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd0}
  };

  // Frame counts for the random phases, extremes included
  logic [lru_pr_pkg::CFG_W-1:0] frame_plan [12] = '{4'd8, 4'd1, 4'd3, 4'd15, 4'd0, 4'd5,
                                                    4'd2, 4'd7, 4'd9, 4'd4, 4'd6, 4'd8};

  // Shadow of the replacement table
  lru_pr_pkg::page_t              shadow_page  [lru_pr_pkg::FRAMES];
  bit                             shadow_valid [lru_pr_pkg::FRAMES];
  int unsigned                    shadow_rank  [lru_pr_pkg::FRAMES];
  int unsigned                    shadow_fill;
  logic [lru_pr_pkg::FAULT_W-1:0] shadow_faults;
  logic [lru_pr_pkg::CFG_W-1:0]   shadow_frames;

  lru_pr_pkg::out_beat_t pending_results [$];
  lru_pr_pkg::out_beat_t predicted;
  bit                    drv_typed = 1'b0;
  lru_pr_pkg::out_beat_t drv_result = '0;
  bit                    quiet_tail = 1'b0;
  int unsigned           result_mismatches = 0;
  int unsigned           cycle_count = 0;
  int unsigned           stall_left = 0;
  int unsigned           run_left = 0;

  lru_page_replacement_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Residency, ranks, fill pointer and fault count back to their reset state
  function automatic void clear_residency();
    for (int f = 0; f < lru_pr_pkg::FRAMES; f++) begin
      shadow_valid[f] = 1'b0;
      shadow_rank[f]  = 0;
    end
    shadow_fill   = 0;
    shadow_faults = '0;
  endfunction

  // True LRU over the managed frames; updates the shadow table
  function automatic lru_pr_pkg::out_beat_t lru_lookup(lru_pr_pkg::in_beat_t b);
    lru_pr_pkg::out_beat_t r;
    int unsigned           n;
    int unsigned           s;
    int unsigned           old_rank;
    bit                    found;
    bit                    empty_found;
    r = '0;
    s = 0;
    found = 1'b0;
    empty_found = 1'b0;
    n = (shadow_frames == 0) ? 1 :
        ((shadow_frames > lru_pr_pkg::FRAMES) ? lru_pr_pkg::FRAMES : shadow_frames);
    // lowest-numbered matching frame wins
    for (int f = 0; f < n; f++) begin
      if (!found && shadow_valid[f] && shadow_page[f] == b.page_number) begin
        found = 1'b1;
        s = f;
      end
    end
    if (!found) begin
      if (shadow_fill < n && !shadow_valid[shadow_fill]) begin
        s = shadow_fill;
        shadow_fill = (shadow_fill + 1 >= n) ? 0 : shadow_fill + 1;
      end else begin
        for (int f = 0; f < n; f++) begin
          if (!empty_found && !shadow_valid[f]) begin
            s = f;
            empty_found = 1'b1;
          end
        end
        // no empty frame: oldest rank, ties to the lowest index
        if (!empty_found) begin
          s = 0;
          for (int f = 1; f < n; f++) begin
            if (shadow_rank[f] > shadow_rank[s]) s = f;
          end
          r.evicted_valid = 1'b1;
          r.evicted_page  = shadow_page[s];
        end
      end
    end
    // age the frames younger than the touched one
    old_rank = shadow_valid[s] ? shadow_rank[s] : 32'hFFFF_FFFF;
    for (int g = 0; g < n; g++) begin
      if (g != s && shadow_valid[g] && shadow_rank[g] < old_rank &&
          shadow_rank[g] < lru_pr_pkg::FRAMES - 1)
        shadow_rank[g]++;
    end
    shadow_rank[s] = 0;
    if (!found) begin
      shadow_page[s]  = b.page_number;
      shadow_valid[s] = 1'b1;
      if (shadow_faults != '1) shadow_faults++;
    end
    r.hit         = found;
    r.frame_slot  = lru_pr_pkg::slot_t'(s);
    r.fault_count = shadow_faults;
    if (b.last_reference) clear_residency();
    return r;
  endfunction

  function automatic void compare_result(lru_pr_pkg::out_beat_t exp_r,
                                         lru_pr_pkg::out_beat_t act_r);
    bit bad;
    bad = (exp_r.hit != act_r.hit) || (exp_r.frame_slot != act_r.frame_slot) ||
          (exp_r.evicted_valid != act_r.evicted_valid) ||
          (exp_r.evicted_page != act_r.evicted_page) ||
          (exp_r.fault_count != act_r.fault_count);
    if (bad) begin
      result_mismatches++;
      if (result_mismatches <= 10)
        $display("%0t mismatch hit/slot/ev/evpage/faults: exp %0d/%0d/%0d/%h/%0d got %0d/%0d/%0d/%h/%0d",
                 $realtime, exp_r.hit, exp_r.frame_slot, exp_r.evicted_valid,
                 exp_r.evicted_page, exp_r.fault_count, act_r.hit, act_r.frame_slot,
                 act_r.evicted_valid, act_r.evicted_page, act_r.fault_count);
    end
  endfunction

  // Beat monitor: config, accepted references, accepted results
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_residency();
      shadow_frames = lru_pr_pkg::CFG_RESET;
      pending_results.delete();
    end else begin
      if (cfg_we) shadow_frames = cfg_data;
      if (in_valid && !in_stall) begin
        predicted = lru_lookup(in_data);
        if (drv_typed) predicted = drv_result;
        pending_results.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          result_mismatches++;
          if (result_mismatches <= 10)
            $display("%0t result beat with nothing outstanding", $realtime);
        end else begin
          compare_result(pending_results.pop_front(), out_data);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      cycle_count <= cycle_count + 1;
    end
  end

  // Result side back-pressure in bursts, off for the tail of the run
  always @(negedge clk) begin
    if (quiet_tail) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (run_left > 0) begin
      out_stall <= 1'b0;
      run_left--;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(1, 13) - 1;
    end else begin
      out_stall <= 1'b0;
      run_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 25);
    end
  end

  // Present one reference beat and hold it until taken
  task automatic send_ref(input lru_pr_pkg::page_t page, input logic last,
                          input bit typed, input lru_pr_pkg::out_beat_t typed_res);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= '{page_number: page, last_reference: last};
    drv_typed  <= typed;
    drv_result <= typed_res;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Frame count is only changed with nothing in flight
  task automatic set_frame_count(input logic [lru_pr_pkg::CFG_W-1:0] count);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= count;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin : stimulus
    lru_pr_pkg::page_t            page_pool [16];
    lru_pr_pkg::page_t            pg;
    logic                         lst;
    logic [lru_pr_pkg::CFG_W-1:0] count;
    int unsigned                  n_eff;
    int unsigned                  pool_span;
    int unsigned                  phase_len;
    int unsigned                  phase;
    int unsigned                  random_sent;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows
    for (int r = 0; r < REF_ROWS; r++) begin
      if (ref_rows[r].kind == ROW_CFG)
        set_frame_count(ref_rows[r].frames);
      else
        send_ref(ref_rows[r].page, ref_rows[r].last, ref_rows[r].typed,
                 '{ref_rows[r].hit, ref_rows[r].slot, ref_rows[r].ev_valid,
                   ref_rows[r].ev_page, ref_rows[r].faults});
    end

    // shared pool so pages outlive frame count changes
    for (int k = 0; k < 16; k++) page_pool[k] = lru_pr_pkg::page_t'($urandom_range(0, 65535));
    page_pool[0] = 16'h0000;
    page_pool[1] = 16'hFFFF;

    // random reference strings, one frame count per phase; the tail stays in one phase
    phase = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      count = (phase < 12) ? frame_plan[phase] :
              lru_pr_pkg::CFG_W'($urandom_range(0, 15));
      set_frame_count(count);
      n_eff = (count == 0) ? 1 :
              ((count > lru_pr_pkg::FRAMES) ? lru_pr_pkg::FRAMES : count);
      pool_span = $urandom_range(1, n_eff + 4);
      phase_len = $urandom_range(20, 45);
      for (int i = 0; (i < phase_len || quiet_tail) && random_sent < RANDOM_ITEMS; i++) begin
        if ($urandom_range(0, 11) == 0)
          pg = lru_pr_pkg::page_t'($urandom_range(0, 65535));
        else
          pg = page_pool[$urandom_range(0, pool_span - 1)];
        lst = ($urandom_range(0, 39) == 0) ||
              (i == phase_len - 1 && $urandom_range(0, 1) == 0);
        quiet_tail = (random_sent >= RANDOM_ITEMS - QUIET_ITEMS);
        send_ref(pg, lst, 1'b0, '0);
        random_sent++;
      end
      phase++;
    end
    in_valid <= 1'b0;

    // drain
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (result_mismatches == 0 && pending_results.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/lru_pr_pkg.sv
sv/lru_pr_lookup.sv
sv/lru_pr_table.sv
sv/lru_page_replacement_top.sv
tb/tb_lru_page_replacement_top.sv
